// ===== src/talq_pkg.sv =====
package talq_pkg;

	localparam int MAX_TILES_PER_ROW = 512;
	localparam int MAX_BLOCK         = 64;
	localparam int LEVELS            = 10;
	localparam int WIDTH_LIMIT       = 4096;

	localparam int BS_W   = 7;
	localparam int IW_W   = 13;
	localparam int TOP_W  = 17;
	localparam int STEP_W = 14;
	localparam int PIX_W  = 8;
	localparam int LVL_W  = 4;
	localparam int SUM_W  = 20;

	localparam int PC_W   = $clog2(WIDTH_LIMIT);
	localparam int CNT_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int K_W    = $clog2(LEVELS);
	localparam int THR_W  = TOP_W + 3;
	localparam int AREA_W = 13;
	localparam int PROD_W = THR_W + AREA_W + 1;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd1;
	localparam logic [1:0] REG_TOP_LEVEL   = 2'd2;
	localparam logic [1:0] REG_LEVEL_STEP  = 2'd3;

	localparam logic [BS_W-1:0]   RST_BLOCK_SIZE  = 7'd8;
	localparam logic [IW_W-1:0]   RST_IMAGE_WIDTH = 13'd640;
	localparam logic [TOP_W-1:0]  RST_TOP_LEVEL   = 17'd32768;
	localparam logic [STEP_W-1:0] RST_LEVEL_STEP  = 14'd3264;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_ACC,
		S_MUL,
		S_CMP,
		S_EMIT
	} state_t;

endpackage

// ===== src/tile_average_level_quantizer.sv =====
// Tile mean brightness classifier for a raster-order grayscale stream.
//
// Pixel channel: pixel and frame_start with pixel_valid / pixel_stall. A
// request with frame_start set clears the position counters and all tile
// accumulators before the pixel is taken into account.
// Result channel: level, tile_column and row_end with tile_valid /
// tile_stall, one request per completed full tile.
// Configuration: APB-style port, registers at 0x0 block_size, 0x4
// image_width, 0x8 top_level, 0xC level_step; write only while idle.
//
// Sequencing: a pixel passes the accumulate step and pixel_stall stays high
// until the sequencer is back in idle. A pixel that completes a tile then
// tries thresholds on the single shared multiplier (up to LEVELS-1 of them),
// each with a multiply and a compare step, then loads the output register.
// A frame_start request first runs a clear pass over all MaxTiles entries
// of the accumulator RAM before its pixel is evaluated.
// Reset runs the same clear pass; pixel_stall stays high until it is done.
// The output register holds one result; a stalled result blocks the next
// completing tile only, earlier pixels keep flowing.
module tile_average_level_quantizer #(
	parameter int MaxTiles = talq_pkg::MAX_TILES_PER_ROW
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         psel,
	input  logic                                         penable,
	input  logic                                         pwrite,
	input  logic [talq_pkg::ADDR_W-1:0]                  paddr,
	input  logic [talq_pkg::DATA_W-1:0]                  pwdata,
	output logic [talq_pkg::DATA_W-1:0]                  prdata,
	output logic                                         pready,
	input  logic                                         pixel_valid,
	output logic                                         pixel_stall,
	input  logic [talq_pkg::PIX_W-1:0]                   pixel,
	input  logic                                         frame_start,
	output logic                                         tile_valid,
	input  logic                                         tile_stall,
	output logic [talq_pkg::LVL_W-1:0]                   level,
	output logic [((MaxTiles > 1) ? $clog2(MaxTiles) : 1)-1:0] tile_column,
	output logic                                         row_end
);
	import talq_pkg::*;

	localparam int TW   = (MaxTiles > 1) ? $clog2(MaxTiles) : 1;
	localparam int TI_W = $clog2(MaxTiles + 1);

	// configuration
	logic [BS_W-1:0]   block_size_q;
	logic [IW_W-1:0]   image_width_q;
	logic [TOP_W-1:0]  top_level_q;
	logic [STEP_W-1:0] level_step_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= RST_BLOCK_SIZE;
			image_width_q <= RST_IMAGE_WIDTH;
			top_level_q   <= RST_TOP_LEVEL;
			level_step_q  <= RST_LEVEL_STEP;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BLOCK_SIZE:  block_size_q  <= pwdata[BS_W-1:0];
				REG_IMAGE_WIDTH: image_width_q <= pwdata[IW_W-1:0];
				REG_TOP_LEVEL:   top_level_q   <= pwdata[TOP_W-1:0];
				REG_LEVEL_STEP:  level_step_q  <= pwdata[STEP_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BLOCK_SIZE:  prdata = DATA_W'(block_size_q);
			REG_IMAGE_WIDTH: prdata = DATA_W'(image_width_q);
			REG_TOP_LEVEL:   prdata = DATA_W'(top_level_q);
			REG_LEVEL_STEP:  prdata = DATA_W'(level_step_q);
		endcase
	end

	// clamped geometry
	logic [BS_W-1:0] b_eff;
	logic [IW_W-1:0] w_eff;

	always_comb begin
		priority if (block_size_q == '0) begin
			b_eff = BS_W'(1);
		end else if (block_size_q > BS_W'(MAX_BLOCK)) begin
			b_eff = BS_W'(MAX_BLOCK);
		end else begin
			b_eff = block_size_q;
		end
		priority if (image_width_q == '0) begin
			w_eff = IW_W'(1);
		end else if (image_width_q > IW_W'(WIDTH_LIMIT)) begin
			w_eff = IW_W'(WIDTH_LIMIT);
		end else begin
			w_eff = image_width_q;
		end
	end

	// sequencer
	state_t state_q, state_d;
	logic   accept, eval_go, clr_cnt, clr_last, load_out, out_free;
	logic   pend_q;
	logic [TW-1:0] clr_q;

	logic [TI_W-1:0]  ti_q;
	logic [PC_W-1:0]  pc_q;
	logic [CNT_W-1:0] row_q, col_q;

	logic [PIX_W-1:0] px_q;
	logic [TW-1:0]    t_q;
	logic             kept_q, first_q, corner_q, last_q;
	logic [SUM_W-1:0] sum_q;
	logic [AREA_W-1:0] area_q;
	logic signed [THR_W-1:0]  thr_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [K_W-1:0]   k_q;
	logic [LVL_W-1:0] lvl_q;

	logic signed [THR_W-1:0]  mul_a;
	logic [AREA_W-1:0]        mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] lhs;
	logic                     above;

	logic              ram_we, ram_re;
	logic [TW-1:0]     ram_waddr;
	logic [SUM_W-1:0]  ram_wdata, ram_rdata, new_sum;

	assign accept   = pixel_valid && !pixel_stall;
	assign clr_last = (clr_q == TW'(MaxTiles - 1));
	assign out_free = !tile_valid || !tile_stall;
	assign lhs      = $signed({{(PROD_W - SUM_W - 8){1'b0}}, sum_q, 8'd0});
	assign above    = lhs > prod_q;

	always_comb begin
		state_d     = state_q;
		pixel_stall = 1'b1;
		eval_go     = 1'b0;
		clr_cnt     = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = pend_q ? S_EVAL : S_IDLE;
				end
			end
			S_IDLE: begin
				pixel_stall = 1'b0;
				if (pixel_valid) begin
					if (frame_start) begin
						clr_cnt = 1'b1;
						state_d = S_CLEAR;
					end else begin
						eval_go = 1'b1;
						state_d = S_ACC;
					end
				end
			end
			S_EVAL: begin
				eval_go = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				state_d = (kept_q && corner_q) ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (above || k_q == K_W'(LEVELS - 1)) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_MUL;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_cnt) begin
				clr_q  <= '0;
				pend_q <= 1'b1;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + TW'(1);
			end else if (state_q == S_EVAL) begin
				pend_q <= 1'b0;
			end
		end
	end

	// position counters and tile evaluation
	logic [PC_W-1:0] start;
	logic            fits, kept, first, corner, last;
	logic            col_wrap, pc_wrap, row_wrap;

	always_comb begin
		start  = pc_q - PC_W'(col_q);
		fits   = (14'(start) + 14'(b_eff)) <= 14'(w_eff);
		kept   = fits && (ti_q < TI_W'(MaxTiles));
		first  = (row_q == '0) && (col_q == '0);
		corner = (BS_W'(row_q) == b_eff - BS_W'(1)) && (BS_W'(col_q) == b_eff - BS_W'(1));
		last   = ((14'(start) + 14'({b_eff, 1'b0})) > 14'(w_eff))
			|| (ti_q == TI_W'(MaxTiles - 1));
		col_wrap = (BS_W'(col_q) + BS_W'(1)) >= b_eff;
		row_wrap = (BS_W'(row_q) + BS_W'(1)) >= b_eff;
		pc_wrap  = (IW_W'(pc_q) + IW_W'(1)) >= w_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q  <= '0;
			pc_q  <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (clr_cnt) begin
			ti_q  <= '0;
			pc_q  <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (eval_go) begin
			if (pc_wrap) begin
				pc_q  <= '0;
				col_q <= '0;
				ti_q  <= '0;
				row_q <= row_wrap ? '0 : row_q + CNT_W'(1);
			end else begin
				pc_q <= pc_q + PC_W'(1);
				if (col_wrap) begin
					col_q <= '0;
					if (ti_q < TI_W'(MaxTiles)) begin
						ti_q <= ti_q + TI_W'(1);
					end
				end else begin
					col_q <= col_q + CNT_W'(1);
				end
			end
		end
	end

	// shared multiplier: tile area, then one threshold product per pass
	always_comb begin
		if (state_q == S_ACC) begin
			mul_a = THR_W'(b_eff);
			mul_b = AREA_W'(b_eff);
		end else begin
			mul_a = thr_q;
			mul_b = area_q;
		end
		mul_p = mul_a * $signed({1'b0, mul_b});
	end

	assign new_sum = first_q ? SUM_W'(px_q) : ram_rdata + SUM_W'(px_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= pixel;
		end
		if (eval_go) begin
			t_q      <= ti_q[TW-1:0];
			kept_q   <= kept;
			first_q  <= first;
			corner_q <= corner;
			last_q   <= last;
		end
		if (state_q == S_ACC) begin
			sum_q  <= new_sum;
			area_q <= mul_p[AREA_W-1:0];
			thr_q  <= $signed(THR_W'(top_level_q)) - $signed(THR_W'(level_step_q));
			k_q    <= K_W'(1);
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_p;
			thr_q  <= thr_q - $signed(THR_W'(level_step_q));
		end
		if (state_q == S_CMP) begin
			if (above) begin
				lvl_q <= LVL_W'(k_q - K_W'(1));
			end else if (k_q == K_W'(LEVELS - 1)) begin
				lvl_q <= LVL_W'(LEVELS - 1);
			end else begin
				k_q <= k_q + K_W'(1);
			end
		end
	end

	// accumulator RAM
	always_comb begin
		ram_re = eval_go;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == S_ACC) && kept_q;
			ram_waddr = t_q;
			ram_wdata = new_sum;
		end
	end

	talq_ram #(
		.Width(SUM_W),
		.Depth(MaxTiles)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ti_q[TW-1:0]),
		.rdata(ram_rdata)
	);

	// output register
	logic             out_valid_q;
	logic [LVL_W-1:0] out_level_q;
	logic [TW-1:0]    out_col_q;
	logic             out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!tile_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_level_q <= lvl_q;
			out_col_q   <= t_q;
			out_end_q   <= last_q;
		end
	end

	assign tile_valid  = out_valid_q;
	assign level       = out_level_q;
	assign tile_column = out_col_q;
	assign row_end     = out_end_q;

	a_plain_pixel_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !frame_start) |=> (state_q == S_ACC))
		else $error("pixel request did not reach accumulate step");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tile_valid) |-> ($past(state_q) == S_EMIT))
		else $error("result appeared outside emit step");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid |-> (level <= LVL_W'(LEVELS - 1)))
		else $error("level out of range");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ((k_q >= K_W'(1)) && (k_q <= K_W'(LEVELS - 1))))
		else $error("threshold index out of range");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_start) |=> (state_q == S_CLEAR) && (clr_q == '0))
		else $error("frame start did not begin a clear pass");
endmodule

// ===== src/talq_ram.sv =====
module talq_ram #(
	parameter int Width = 20,
	parameter int Depth = 512
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                        rdata
);
	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
